// ----- sv/additive_dual_bound_step_macros.svh -----
// Assertion macros for the additive dual bound step block.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef ADDITIVE_DUAL_BOUND_STEP_MACROS_SVH
`define ADDITIVE_DUAL_BOUND_STEP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADBS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adbs same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ADBS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adbs next-cycle check failed");

`endif

// ----- sv/adbs_pkg.sv -----
// Shared types, sizes and codes for the additive dual bound step block.
// No dependencies; the design files refer to it by scoped names and the testbench files import it.
package adbs_pkg;

  // Table and store sizes.
  localparam int MAX_POSITIONS = 16;
  localparam int MAX_ACTIONS   = 4;
  localparam int POS_W         = 4;
  localparam int ACT_W         = 2;
  localparam int TBL_W         = POS_W + ACT_W;
  localparam int VAL_W         = 48;
  localparam int OP_W          = 3;
  localparam int ST_W          = 2;
  localparam int NP_W          = 5;
  localparam int NA_W          = 3;

  // Configuration port.
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_IDX_BIT   = 2;
  localparam logic REG_POSITIONS = 1'b0;
  localparam logic REG_ACTIONS   = 1'b1;
  localparam logic [NP_W-1:0] POSITIONS_RESET = NP_W'(MAX_POSITIONS);
  localparam logic [NA_W-1:0] ACTIONS_RESET   = NA_W'(MAX_ACTIONS);

  // Opcodes.
  localparam logic [OP_W-1:0] OP_SET_NEXT   = 3'd0;
  localparam logic [OP_W-1:0] OP_TERMINAL   = 3'd1;
  localparam logic [OP_W-1:0] OP_MARTINGALE = 3'd2;
  localparam logic [OP_W-1:0] OP_REWARD     = 3'd3;
  localparam logic [OP_W-1:0] OP_EVALUATE   = 3'd4;
  localparam logic [OP_W-1:0] OP_ADVANCE    = 3'd5;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_SAT   = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic [POS_W-1:0]        position;
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]        position_out;
    logic signed [VAL_W-1:0] primal_value;
    logic signed [VAL_W-1:0] dual_value;
    logic [ST_W-1:0]         status;
  } result_t;

  // Effective counts after clamping the configuration registers.
  typedef struct packed {
    logic [NP_W-1:0] np;
    logic [NA_W-1:0] na;
  } cfg_eff_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic             item_load;
    logic             wr_next;
    logic             wr_term;
    logic             wr_mart;
    logic             wr_rew;
    logic             eval_start;
    logic             rd_issue;
    logic [ACT_W-1:0] rd_act;
    logic             cp_issue;
    logic [POS_W-1:0] cp_idx;
    logic             out_load;
    logic [ST_W-1:0]  out_status;
    logic             out_vals;
    logic             cur_wr;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            pos_ok;
    logic            act_ok;
    logic            tgt_ok;
    logic            pipe_busy;
    logic            eval_bad;
    logic            eval_sat;
    logic            out_free;
  } dp_stat_t;

endpackage

// ----- sv/adbs_ifs.sv -----
// Valid/ready channel interfaces for items and results.
// Depends on adbs_pkg for field widths.
interface adbs_in_if;
  logic                                valid;
  logic                                ready;
  logic [adbs_pkg::OP_W-1:0]           opcode;
  logic [adbs_pkg::POS_W-1:0]          position;
  logic [adbs_pkg::ACT_W-1:0]          action;
  logic signed [adbs_pkg::VAL_W-1:0]   value;

  modport source (output valid, opcode, position, action, value, input ready);
  modport sink (input valid, opcode, position, action, value, output ready);
endinterface

interface adbs_out_if;
  logic                                valid;
  logic                                ready;
  logic [adbs_pkg::POS_W-1:0]          position_out;
  logic signed [adbs_pkg::VAL_W-1:0]   primal_value;
  logic signed [adbs_pkg::VAL_W-1:0]   dual_value;
  logic [adbs_pkg::ST_W-1:0]           status;

  modport source (output valid, position_out, primal_value, dual_value, status,
                  input ready);
  modport sink (input valid, position_out, primal_value, dual_value, status,
                output ready);
endinterface

// ----- sv/adbs_cfg.sv -----
// APB-style register file for the position and action counts.
// Depends on adbs_pkg; outputs the clamped counts used by the block.
module adbs_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [adbs_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [adbs_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [adbs_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output adbs_pkg::cfg_eff_t                eff
);

  logic [adbs_pkg::NP_W-1:0] pos_reg_r;
  logic [adbs_pkg::NA_W-1:0] act_reg_r;
  logic                      wr_en;
  logic                      sel_act;

  assign wr_en   = psel && penable && pwrite;
  assign sel_act = (paddr[adbs_pkg::CFG_IDX_BIT] == adbs_pkg::REG_ACTIONS);
  assign pready  = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_reg_r <= adbs_pkg::POSITIONS_RESET;
      act_reg_r <= adbs_pkg::ACTIONS_RESET;
    end else if (wr_en) begin
      if (sel_act) begin
        act_reg_r <= pwdata[adbs_pkg::NA_W-1:0];
      end else begin
        pos_reg_r <= pwdata[adbs_pkg::NP_W-1:0];
      end
    end
  end

  // Read data returns the raw register value.
  always_comb begin
    if (sel_act) begin
      prdata = adbs_pkg::CFG_DATA_W'(act_reg_r);
    end else begin
      prdata = adbs_pkg::CFG_DATA_W'(pos_reg_r);
    end
  end

  // A zero count acts as one, and a count above the table size is capped.
  always_comb begin
    if (pos_reg_r == '0) begin
      eff.np = adbs_pkg::NP_W'(1);
    end else if (pos_reg_r > adbs_pkg::NP_W'(adbs_pkg::MAX_POSITIONS)) begin
      eff.np = adbs_pkg::NP_W'(adbs_pkg::MAX_POSITIONS);
    end else begin
      eff.np = pos_reg_r;
    end
    if (act_reg_r == '0) begin
      eff.na = adbs_pkg::NA_W'(1);
    end else if (act_reg_r > adbs_pkg::NA_W'(adbs_pkg::MAX_ACTIONS)) begin
      eff.na = adbs_pkg::NA_W'(adbs_pkg::MAX_ACTIONS);
    end else begin
      eff.na = act_reg_r;
    end
  end

endmodule

// ----- sv/adbs_ctrl.sv -----
// Controller state machine: decodes each word and sequences loads, the
// evaluate walk over actions, the advance copy and the result hand-off. Uses adbs_pkg.
module adbs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  adbs_pkg::cfg_eff_t   eff,
  input  adbs_pkg::dp_stat_t   stat,
  output adbs_pkg::dp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_EVAL   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_COPY   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]                state_r, state_nxt;
  logic [adbs_pkg::POS_W-1:0] cnt_r, cnt_nxt;
  logic [adbs_pkg::ST_W-1:0]  status_r, status_nxt;
  logic                       vals_r, vals_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      status_r <= adbs_pkg::ST_OK;
      vals_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      status_r <= status_nxt;
      vals_r   <= vals_nxt;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    vals_nxt   = vals_r;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.rd_act = cnt_r[adbs_pkg::ACT_W-1:0];
    cmd.cp_idx = cnt_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        status_nxt = adbs_pkg::ST_OK;
        vals_nxt   = 1'b0;
        cnt_nxt    = '0;
        state_nxt  = S_FINISH;
        case (stat.opcode)
          adbs_pkg::OP_SET_NEXT: begin
            if (stat.pos_ok && stat.act_ok && stat.tgt_ok) begin
              cmd.wr_next = 1'b1;
            end else begin
              status_nxt = adbs_pkg::ST_RANGE;
            end
          end
          adbs_pkg::OP_TERMINAL: begin
            if (stat.pos_ok) begin
              cmd.wr_term = 1'b1;
            end else begin
              status_nxt = adbs_pkg::ST_RANGE;
            end
          end
          adbs_pkg::OP_MARTINGALE: begin
            if (stat.pos_ok) begin
              cmd.wr_mart = 1'b1;
            end else begin
              status_nxt = adbs_pkg::ST_RANGE;
            end
          end
          adbs_pkg::OP_REWARD: begin
            if (stat.pos_ok && stat.act_ok) begin
              cmd.wr_rew = 1'b1;
            end else begin
              status_nxt = adbs_pkg::ST_RANGE;
            end
          end
          adbs_pkg::OP_EVALUATE: begin
            if (stat.pos_ok && stat.act_ok) begin
              cmd.eval_start = 1'b1;
              state_nxt      = S_EVAL;
            end else begin
              status_nxt = adbs_pkg::ST_RANGE;
            end
          end
          adbs_pkg::OP_ADVANCE: begin
            state_nxt = S_COPY;
          end
          default: begin
            status_nxt = adbs_pkg::ST_RANGE;
          end
        endcase
      end
      // One table read per action in use.
      S_EVAL: begin
        cmd.rd_issue = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (adbs_pkg::NA_W'(cnt_r[adbs_pkg::ACT_W-1:0]) == eff.na - 1'b1) begin
          state_nxt = S_DRAIN;
        end
      end
      // Wait for the sum and max stages to empty, then grade the result.
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          vals_nxt  = !stat.eval_bad;
          state_nxt = S_FINISH;
          if (stat.eval_bad) begin
            status_nxt = adbs_pkg::ST_RANGE;
          end else if (stat.eval_sat) begin
            status_nxt = adbs_pkg::ST_SAT;
          end else begin
            status_nxt = adbs_pkg::ST_OK;
          end
        end
      end
      // Copy the current stores into the next-epoch stores, one entry a cycle.
      S_COPY: begin
        cmd.cp_issue = 1'b1;
        if (cnt_r == adbs_pkg::POS_W'(adbs_pkg::MAX_POSITIONS - 1)) begin
          state_nxt = S_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = status_r;
          cmd.out_vals   = vals_r;
          cmd.cur_wr     = vals_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/adbs_dp.sv -----
// Datapath: table and store memories, the three-stage sum and max pipeline,
// the advance copy path and the output register. Uses adbs_pkg.
module adbs_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  adbs_pkg::item_t      in_item,
  input  adbs_pkg::cfg_eff_t   eff,
  input  adbs_pkg::dp_cmd_t    cmd,
  output adbs_pkg::dp_stat_t   stat,
  output adbs_pkg::result_t    out_res,
  output logic                 out_valid,
  input  logic                 out_ready
);

  localparam int SUM_W = adbs_pkg::VAL_W + 2;

  typedef struct packed {
    logic                             sat;
    logic signed [adbs_pkg::VAL_W-1:0] value;
  } sum_t;

  // Exact three-term sum clamped to the value width.
  function automatic sum_t sum3_sat(input logic signed [adbs_pkg::VAL_W-1:0] a,
                                    input logic signed [adbs_pkg::VAL_W-1:0] b,
                                    input logic signed [adbs_pkg::VAL_W-1:0] c);
    logic signed [SUM_W-1:0] s;
    sum_t                    r;
    s = SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
    if ((s[SUM_W-1:adbs_pkg::VAL_W-1] == '0) || (s[SUM_W-1:adbs_pkg::VAL_W-1] == '1)) begin
      r.sat   = 1'b0;
      r.value = s[adbs_pkg::VAL_W-1:0];
    end else begin
      r.sat   = 1'b1;
      r.value = s[SUM_W-1] ? {1'b1, {(adbs_pkg::VAL_W-1){1'b0}}}
                           : {1'b0, {(adbs_pkg::VAL_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Memories.
  logic [adbs_pkg::POS_W-1:0]        next_mem  [adbs_pkg::MAX_POSITIONS*adbs_pkg::MAX_ACTIONS];
  logic signed [adbs_pkg::VAL_W-1:0] rew_mem   [adbs_pkg::MAX_POSITIONS*adbs_pkg::MAX_ACTIONS];
  logic signed [adbs_pkg::VAL_W-1:0] mart_mem  [adbs_pkg::MAX_POSITIONS];
  logic signed [adbs_pkg::VAL_W-1:0] pnext_mem [adbs_pkg::MAX_POSITIONS];
  logic signed [adbs_pkg::VAL_W-1:0] dnext_mem [adbs_pkg::MAX_POSITIONS];
  logic signed [adbs_pkg::VAL_W-1:0] pcur_mem  [adbs_pkg::MAX_POSITIONS];
  logic signed [adbs_pkg::VAL_W-1:0] dcur_mem  [adbs_pkg::MAX_POSITIONS];

  adbs_pkg::item_t                   item_r;
  logic [adbs_pkg::TBL_W-1:0]        waddr;
  logic [adbs_pkg::TBL_W-1:0]        raddr;

  // Pipeline registers.
  logic                              s1_v_r, s2_v_r, s3_v_r;
  logic [adbs_pkg::ACT_W-1:0]        s1_a_r, s2_a_r, s3_a_r;
  logic [adbs_pkg::POS_W-1:0]        next_q_r;
  logic signed [adbs_pkg::VAL_W-1:0] rew_q_r, rew2_r;
  logic signed [adbs_pkg::VAL_W-1:0] mart_q_r, pn_q_r, dn_q_r;
  logic signed [adbs_pkg::VAL_W-1:0] pc_r, dc_r;
  logic                              ps_r, ds_r;
  logic signed [adbs_pkg::VAL_W-1:0] primal_r, dmax_r;
  logic                              bad_r, sat_r;
  sum_t                              psum, dsum;

  // Copy path.
  logic                              cp_v_r;
  logic [adbs_pkg::POS_W-1:0]        cp_idx_r;
  logic signed [adbs_pkg::VAL_W-1:0] pcur_q_r, dcur_q_r;
  logic                              pn_we;
  logic [adbs_pkg::POS_W-1:0]        pn_waddr;
  logic signed [adbs_pkg::VAL_W-1:0] pn_wdata, dn_wdata;

  // Output register.
  adbs_pkg::result_t                 out_r;
  logic                              out_valid_r;

  assign waddr = {item_r.position, item_r.action};
  assign raddr = {item_r.position, cmd.rd_act};

  // Item register.
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_r <= in_item;
    end
  end

  // Next-position and reward tables.
  always_ff @(posedge clk) begin
    if (cmd.wr_next) begin
      next_mem[waddr] <= item_r.value[adbs_pkg::POS_W-1:0];
    end
    if (cmd.rd_issue) begin
      next_q_r <= next_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_rew) begin
      rew_mem[waddr] <= item_r.value;
    end
    if (cmd.rd_issue) begin
      rew_q_r <= rew_mem[raddr];
    end
  end

  // Martingale store, read at the next position.
  always_ff @(posedge clk) begin
    if (cmd.wr_mart) begin
      mart_mem[item_r.position] <= item_r.value;
    end
    if (s1_v_r) begin
      mart_q_r <= mart_mem[next_q_r];
    end
  end

  // Next-epoch stores: written by terminal words or by the advance copy.
  assign pn_we    = cmd.wr_term || cp_v_r;
  assign pn_waddr = cmd.wr_term ? item_r.position : cp_idx_r;
  assign pn_wdata = cmd.wr_term ? item_r.value : pcur_q_r;
  assign dn_wdata = cmd.wr_term ? item_r.value : dcur_q_r;

  always_ff @(posedge clk) begin
    if (pn_we) begin
      pnext_mem[pn_waddr] <= pn_wdata;
    end
    if (s1_v_r) begin
      pn_q_r <= pnext_mem[next_q_r];
    end
  end

  always_ff @(posedge clk) begin
    if (pn_we) begin
      dnext_mem[pn_waddr] <= dn_wdata;
    end
    if (s1_v_r) begin
      dn_q_r <= dnext_mem[next_q_r];
    end
  end

  // Current-epoch stores: written at the end of an evaluate with no range error.
  always_ff @(posedge clk) begin
    if (cmd.cur_wr) begin
      pcur_mem[item_r.position] <= primal_r;
    end
    if (cmd.cp_issue) begin
      pcur_q_r <= pcur_mem[cmd.cp_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cur_wr) begin
      dcur_mem[item_r.position] <= dmax_r;
    end
    if (cmd.cp_issue) begin
      dcur_q_r <= dcur_mem[cmd.cp_idx];
    end
  end

  // Pipeline valid bits and copy tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      cp_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.rd_issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      cp_v_r <= cmd.cp_issue;
    end
  end

  always_ff @(posedge clk) begin
    cp_idx_r <= cmd.cp_idx;
    s1_a_r   <= cmd.rd_act;
    s2_a_r   <= s1_a_r;
    s3_a_r   <= s2_a_r;
    if (s1_v_r) begin
      rew2_r <= rew_q_r;
    end
  end

  // Sum stage: primal and dual candidates for one action.
  assign psum = sum3_sat(rew2_r, mart_q_r, pn_q_r);
  assign dsum = sum3_sat(rew2_r, mart_q_r, dn_q_r);

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      pc_r <= psum.value;
      dc_r <= dsum.value;
      ps_r <= psum.sat;
      ds_r <= dsum.sat;
    end
  end

  // Max stage, plus range and saturation flags for the whole evaluate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_r <= 1'b0;
      sat_r <= 1'b0;
    end else if (cmd.eval_start) begin
      bad_r <= 1'b0;
      sat_r <= 1'b0;
    end else begin
      if (s1_v_r && ({1'b0, next_q_r} >= eff.np)) begin
        bad_r <= 1'b1;
      end
      if (s3_v_r && (ds_r || (ps_r && (s3_a_r == item_r.action)))) begin
        sat_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r) begin
      if ((s3_a_r == '0) || (dc_r > dmax_r)) begin
        dmax_r <= dc_r;
      end
      if (s3_a_r == item_r.action) begin
        primal_r <= pc_r;
      end
    end
  end

  // Output register: loaded when empty or being drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.position_out <= item_r.position;
      out_r.primal_value <= cmd.out_vals ? primal_r : '0;
      out_r.dual_value   <= cmd.out_vals ? dmax_r : '0;
      out_r.status       <= cmd.out_status;
    end
  end

  assign out_res   = out_r;
  assign out_valid = out_valid_r;

  // Status back to the controller.
  assign stat.opcode    = item_r.opcode;
  assign stat.pos_ok    = ({1'b0, item_r.position} < eff.np);
  assign stat.act_ok    = (adbs_pkg::NA_W'(item_r.action) < eff.na);
  assign stat.tgt_ok    = ($unsigned(item_r.value) < adbs_pkg::VAL_W'(eff.np));
  assign stat.pipe_busy = s1_v_r || s2_v_r || s3_v_r;
  assign stat.eval_bad  = bad_r;
  assign stat.eval_sat  = sat_r;
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

// ----- sv/additive_dual_bound_step.sv -----
// Additive dual bound step: one backward-induction step of primal and dual
// value bounds for one sample path. Uses adbs_pkg, adbs_ifs, adbs_cfg,
// adbs_ctrl, adbs_dp and the assertion macro header.
//
// Usage: words enter on in_ch (valid/ready) and each word returns exactly
// one result word on out_ch. Load words fill the next-position and reward
// tables and the martingale and terminal stores; an evaluate word returns
// the primal value and the dual maximum for one position; an advance word
// copies the current stores into the next-epoch stores.
// The counts in use are written on the cfg_ APB port (0x0 positions,
// 0x4 actions); the user must write them only while the block is idle,
// as the block itself does not enforce it; pready is tied high.
// Flow: an accepted word is registered, decoded and its result loaded
// into the output register. An evaluate issues one table read per action
// in use to the shared sum-and-max pipeline, which then drains three stages.
// An advance copies all 16 store entries through one memory port each.
// One word is in work at a time; the next is accepted the cycle after the
// current result is loaded into the output register, so a stalled receiver
// delays intake only when a second result is ready to leave. Reset empties
// the output register and sets the counts to 16 and 4; tables are not cleared.
`include "additive_dual_bound_step_macros.svh"

module additive_dual_bound_step (
  input  logic                              clk,
  input  logic                              rst_n,
  adbs_in_if.sink                           in_ch,
  adbs_out_if.source                        out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [adbs_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [adbs_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [adbs_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  adbs_pkg::cfg_eff_t eff;
  adbs_pkg::dp_cmd_t  cmd;
  adbs_pkg::dp_stat_t stat;
  adbs_pkg::item_t    in_item;
  adbs_pkg::result_t  out_res;
  logic               in_ready;
  logic               out_valid;

  // Channel payload to and from the internal structs.
  assign in_item.opcode   = in_ch.opcode;
  assign in_item.position = in_ch.position;
  assign in_item.action   = in_ch.action;
  assign in_item.value    = in_ch.value;
  assign in_ch.ready      = in_ready;

  assign out_ch.valid        = out_valid;
  assign out_ch.position_out = out_res.position_out;
  assign out_ch.primal_value = out_res.primal_value;
  assign out_ch.dual_value   = out_res.dual_value;
  assign out_ch.status       = out_res.status;

  adbs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .eff     (eff)
  );

  adbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .eff      (eff),
    .stat     (stat),
    .cmd      (cmd)
  );

  adbs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .eff       (eff),
    .cmd       (cmd),
    .stat      (stat),
    .out_res   (out_res),
    .out_valid (out_valid),
    .out_ready (out_ch.ready)
  );

  // A word is taken only once; intake closes right after an acceptance.
  `ADBS_ASSERT_NXT(a_single_intake, in_ch.valid && in_ch.ready, !in_ch.ready)
  // Rejected words never carry values.
  `ADBS_ASSERT_IMP(a_range_zero, out_ch.valid && (out_ch.status == adbs_pkg::ST_RANGE), (out_ch.primal_value == '0) && (out_ch.dual_value == '0))
  // Only the defined status codes leave the block.
  `ADBS_ASSERT_IMP(a_status_code, out_ch.valid, (out_ch.status == adbs_pkg::ST_OK) || (out_ch.status == adbs_pkg::ST_RANGE) || (out_ch.status == adbs_pkg::ST_SAT))
  // A result is loaded only while the controller holds off intake.
  `ADBS_ASSERT_IMP(a_load_not_idle, cmd.out_load, !in_ready)

endmodule

// ----- tb/sv/adbs_result_checker.sv -----
// Result checker for the additive dual bound step block: watches the item, result
// and register channels, predicts every result word and compares it field by field.
// Depends on adbs_pkg and the channel interfaces in adbs_ifs.
module adbs_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  adbs_in_if                              in_ch,
  adbs_out_if                             out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [adbs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [adbs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input  logic [adbs_pkg::CFG_DATA_W-1:0] cfg_prdata,
  input  logic                            cfg_pready,
  output int                              failures,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import adbs_pkg::*;

  localparam int TABLE_DEPTH = MAX_POSITIONS * MAX_ACTIONS;
  localparam logic signed [VAL_W-1:0] VAL_TOP    = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_BOTTOM = {1'b1, {(VAL_W-1){1'b0}}};

  // Shadow copy of the block's tables, stores and count registers.
  logic [POS_W-1:0]        next_pos   [TABLE_DEPTH];
  logic signed [VAL_W-1:0] reward     [TABLE_DEPTH];
  logic signed [VAL_W-1:0] mart       [MAX_POSITIONS];
  logic signed [VAL_W-1:0] primal_nxt [MAX_POSITIONS];
  logic signed [VAL_W-1:0] dual_nxt   [MAX_POSITIONS];
  logic signed [VAL_W-1:0] primal_cur [MAX_POSITIONS];
  logic signed [VAL_W-1:0] dual_cur   [MAX_POSITIONS];
  logic [NP_W-1:0]         positions_reg;
  logic [NA_W-1:0]         actions_reg;

  result_t expected_bounds[$];
  int      bad_count = 0;

  // A zero register counts as one; anything above the size counts as the size.
  function automatic int eff_count(input int raw, input int cap);
    if (raw == 0) return 1;
    return (raw > cap) ? cap : raw;
  endfunction

  // Exact three-term sum, clamped to the 48-bit range.
  function automatic logic signed [VAL_W-1:0] clamp_sum(input logic signed [VAL_W-1:0] a,
                                                        input logic signed [VAL_W-1:0] b,
                                                        input logic signed [VAL_W-1:0] c,
                                                        inout bit clipped);
    logic signed [VAL_W+1:0] s;
    s = a + b + c;
    if (s[VAL_W+1:VAL_W-1] == 3'b000 || s[VAL_W+1:VAL_W-1] == 3'b111) return s[VAL_W-1:0];
    clipped = 1'b1;
    return s[VAL_W+1] ? VAL_BOTTOM : VAL_TOP;
  endfunction

  // Applies one accepted word to the shadow state and returns its result word.
  function automatic result_t predict_bounds(input item_t w);
    int np, na, a, k, n, base;
    bit pos_ok, act_ok, ok, clipped;
    logic signed [VAL_W-1:0] primal, dual, cand;
    result_t r;
    np      = eff_count(int'(positions_reg), MAX_POSITIONS);
    na      = eff_count(int'(actions_reg), MAX_ACTIONS);
    pos_ok  = int'(w.position) < np;
    act_ok  = int'(w.action) < na;
    base    = int'(w.position) * MAX_ACTIONS;
    k       = base + int'(w.action);
    clipped = 1'b0;
    primal  = '0;
    dual    = '0;
    r = '0;
    r.position_out = w.position;
    r.status       = ST_OK;
    case (w.opcode)
      OP_SET_NEXT: begin
        if (pos_ok && act_ok && $signed(w.value) >= 0 && $signed(w.value) < np)
          next_pos[k] = w.value[POS_W-1:0];
        else
          r.status = ST_RANGE;
      end
      OP_TERMINAL: begin
        if (pos_ok) begin
          primal_nxt[w.position] = w.value;
          dual_nxt[w.position]   = w.value;
        end else begin
          r.status = ST_RANGE;
        end
      end
      OP_MARTINGALE: begin
        if (pos_ok) mart[w.position] = w.value;
        else r.status = ST_RANGE;
      end
      OP_REWARD: begin
        if (pos_ok && act_ok) reward[k] = w.value;
        else r.status = ST_RANGE;
      end
      OP_EVALUATE: begin
        // Every stored next position of the examined actions must be in range.
        ok = pos_ok && act_ok;
        if (ok) begin
          for (a = 0; a < na; a++)
            if (int'(next_pos[base + a]) >= np) ok = 1'b0;
        end
        if (!ok) begin
          r.status = ST_RANGE;
        end else begin
          n = next_pos[k];
          primal = clamp_sum(reward[k], mart[n], primal_nxt[n], clipped);
          for (a = 0; a < na; a++) begin
            n = next_pos[base + a];
            cand = clamp_sum(reward[base + a], mart[n], dual_nxt[n], clipped);
            if (a == 0 || cand > dual) dual = cand;
          end
          primal_cur[w.position] = primal;
          dual_cur[w.position]   = dual;
          r.primal_value = primal;
          r.dual_value   = dual;
          if (clipped) r.status = ST_SAT;
        end
      end
      OP_ADVANCE: begin
        primal_nxt = primal_cur;
        dual_nxt   = dual_cur;
      end
      default: r.status = ST_RANGE;
    endcase
    return r;
  endfunction

  task automatic check_field(input string field, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      bad_count++;
    end
  endtask

  // Sample all channels at the clock edge; results are matched before new words
  // are predicted so a word never meets its own result.
  always @(posedge clk) begin
    result_t got, want;
    item_t   w;
    if (!rst_n) begin
      expected_bounds.delete();
      positions_reg = POSITIONS_RESET;
      actions_reg   = ACTIONS_RESET;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.position_out, out_ch.primal_value, out_ch.dual_value, out_ch.status};
        if (expected_bounds.size() == 0) begin
          $display("%0t: result word with nothing expected, got %h", $time, got);
          bad_count++;
        end else begin
          want = expected_bounds.pop_front();
          check_field("position_out", want.position_out, got.position_out);
          check_field("primal_value", want.primal_value, got.primal_value);
          check_field("dual_value", want.dual_value, got.dual_value);
          check_field("status", want.status, got.status);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        w = {in_ch.opcode, in_ch.position, in_ch.action, in_ch.value};
        expected_bounds.push_back(predict_bounds(w));
      end
      // Register writes update the counts; reads must return the stored value.
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr[CFG_IDX_BIT] == REG_POSITIONS) positions_reg = cfg_pwdata[NP_W-1:0];
          else actions_reg = cfg_pwdata[NA_W-1:0];
        end else begin
          check_field("register read",
                      (cfg_paddr[CFG_IDX_BIT] == REG_POSITIONS) ? 64'(positions_reg)
                                                                 : 64'(actions_reg),
                      cfg_prdata);
        end
      end
    end
    pending  <= expected_bounds.size();
    failures <= bad_count;
  end

endmodule

// ----- tb/sv/tb_additive_dual_bound_step.sv -----
// Testbench top for the additive dual bound step block: clock, reset, word and
// register stimulus, and the verdict. Depends on adbs_pkg, adbs_ifs, the block
// and adbs_result_checker, which does all prediction and comparison.
module tb_additive_dual_bound_step;
  timeunit 1ns;
  timeprecision 1ps;
  import adbs_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int TABLE_DEPTH   = MAX_POSITIONS * MAX_ACTIONS;
  localparam int PHASE_WORDS   = 225;
  localparam int SETTING_COUNT = 8;
  localparam logic signed [VAL_W-1:0] VAL_TOP    = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_BOTTOM = {1'b1, {(VAL_W-1){1'b0}}};

  // Register settings per phase; the first one is the reset setting.
  localparam int NP_SETTINGS[SETTING_COUNT] = '{16, 1, 0, 31, 16, 9, 2, 12};
  localparam int NA_SETTINGS[SETTING_COUNT] = '{4, 1, 0, 7, 4, 3, 4, 2};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata, cfg_prdata;
  int                    failures, pending;

  adbs_in_if  in_ch();
  adbs_out_if out_ch();

  additive_dual_bound_step dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  adbs_result_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .failures   (failures),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Which entries hold written data, so that no evaluate reads an unwritten one.
  bit               nxt_def [TABLE_DEPTH];
  bit               rew_def [TABLE_DEPTH];
  bit               mart_def[MAX_POSITIONS];
  bit               term_def[MAX_POSITIONS];
  bit               cur_def [MAX_POSITIONS];
  logic [POS_W-1:0] nxt_val [TABLE_DEPTH];

  int np_eff, na_eff;
  int words_sent = 0;
  int evals_sent = 0;
  bit steady = 1'b0;

  function automatic logic signed [VAL_W-1:0] draw_wide();
    return VAL_W'({$urandom(), $urandom()});
  endfunction

  // Mostly moderate values, with full-range and extreme values to reach saturation.
  function automatic logic signed [VAL_W-1:0] draw_value();
    logic signed [VAL_W-1:0] v;
    v = draw_wide();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = {{(VAL_W-36){v[35]}}, v[35:0]};
      8: v = VAL_TOP;
      9: v = VAL_BOTTOM;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    if ($urandom_range(0, 7) == 0) return POS_W'($urandom_range(0, MAX_POSITIONS - 1));
    return POS_W'($urandom_range(0, np_eff - 1));
  endfunction

  function automatic logic [ACT_W-1:0] pick_act();
    if ($urandom_range(0, 7) == 0) return ACT_W'($urandom_range(0, MAX_ACTIONS - 1));
    return ACT_W'($urandom_range(0, na_eff - 1));
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_target();
    case ($urandom_range(0, 9))
      0: return VAL_W'(np_eff);
      1: return draw_wide();
      default: return VAL_W'($urandom_range(0, np_eff - 1));
    endcase
  endfunction

  // Tracks which entries a word leaves written.
  function automatic void note_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                    input logic [ACT_W-1:0] act,
                                    input logic signed [VAL_W-1:0] val);
    int  a, base;
    bit  pos_ok, act_ok, lands;
    pos_ok = int'(pos) < np_eff;
    act_ok = int'(act) < na_eff;
    base   = int'(pos) * MAX_ACTIONS;
    case (op)
      OP_SET_NEXT: begin
        if (pos_ok && act_ok && val >= 0 && val < np_eff) begin
          nxt_def[base + act] = 1'b1;
          nxt_val[base + act] = val[POS_W-1:0];
        end
      end
      OP_TERMINAL:   if (pos_ok) term_def[pos] = 1'b1;
      OP_MARTINGALE: if (pos_ok) mart_def[pos] = 1'b1;
      OP_REWARD:     if (pos_ok && act_ok) rew_def[base + act] = 1'b1;
      OP_EVALUATE: begin
        if (pos_ok && act_ok) begin
          lands = 1'b1;
          for (a = 0; a < na_eff; a++)
            if (int'(nxt_val[base + a]) >= np_eff) lands = 1'b0;
          if (lands) cur_def[pos] = 1'b1;
        end
      end
      OP_ADVANCE: term_def = cur_def;
      default: ;
    endcase
  endfunction

  // Finds the first load an evaluate of this position still needs.
  function automatic bit find_gap(input logic [POS_W-1:0] pos, output logic [OP_W-1:0] op,
                                  output logic [POS_W-1:0] fpos,
                                  output logic [ACT_W-1:0] fact);
    int a, k, n;
    for (a = 0; a < na_eff; a++) begin
      k    = int'(pos) * MAX_ACTIONS + a;
      fpos = pos;
      fact = ACT_W'(a);
      op   = OP_SET_NEXT;
      if (!nxt_def[k]) return 1'b1;
      op = OP_REWARD;
      if (!rew_def[k]) return 1'b1;
      n = nxt_val[k];
      if (n < np_eff) begin
        fpos = POS_W'(n);
        op   = OP_MARTINGALE;
        if (!mart_def[n]) return 1'b1;
        op = OP_TERMINAL;
        if (!term_def[n]) return 1'b1;
      end else if (!mart_def[n] || !term_def[n]) begin
        // A stale target whose stores were never written: point it elsewhere.
        op = OP_SET_NEXT;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Sends one word after a random gap and waits for its handshake.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [ACT_W-1:0] act, input logic signed [VAL_W-1:0] val);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.position <= pos;
    in_ch.action   <= act;
    in_ch.value    <= val;
    note_item(op, pos, act, val);
    words_sent++;
    if (op == OP_EVALUATE) evals_sent++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // An evaluate preceded by whatever loads it needs, with random content.
  task automatic make_eval(input logic [POS_W-1:0] pos, input logic [ACT_W-1:0] act);
    logic [OP_W-1:0]  fop;
    logic [POS_W-1:0] fpos;
    logic [ACT_W-1:0] fact;
    if (int'(pos) < np_eff && int'(act) < na_eff) begin
      while (find_gap(pos, fop, fpos, fact))
        send_item(fop, fpos, fact,
                  (fop == OP_SET_NEXT) ? VAL_W'($urandom_range(0, np_eff - 1)) : draw_value());
    end
    send_item(OP_EVALUATE, pos, act, draw_value());
  endtask

  task automatic cfg_access(input logic idx, input logic wr, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= CFG_ADDR_W'(idx) << CFG_IDX_BIT;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes both counts with random upper bits, then reads them back.
  task automatic set_counts(input int np_raw, input int na_raw);
    logic [CFG_DATA_W-1:0] d;
    d = $urandom();
    d[NP_W-1:0] = NP_W'(np_raw);
    cfg_access(REG_POSITIONS, 1'b1, d);
    d = $urandom();
    d[NA_W-1:0] = NA_W'(na_raw);
    cfg_access(REG_ACTIONS, 1'b1, d);
    cfg_access(REG_POSITIONS, 1'b0, '0);
    cfg_access(REG_ACTIONS, 1'b0, '0);
    np_eff = (np_raw == 0) ? 1 : ((np_raw > MAX_POSITIONS) ? MAX_POSITIONS : np_raw);
    na_eff = (na_raw == 0) ? 1 : ((na_raw > MAX_ACTIONS) ? MAX_ACTIONS : na_raw);
  endtask

  // Drops valid and waits until every expected result word has been taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Both saturation directions, range errors on set next, unknown opcodes, advance.
  task automatic run_directed();
    int a;
    for (a = 0; a < MAX_ACTIONS; a++) begin
      send_item(OP_SET_NEXT, POS_W'(0), ACT_W'(a), VAL_W'(MAX_POSITIONS - 1));
      send_item(OP_SET_NEXT, POS_W'(MAX_POSITIONS - 1), ACT_W'(a), '0);
      send_item(OP_REWARD, POS_W'(0), ACT_W'(a), VAL_TOP);
      send_item(OP_REWARD, POS_W'(MAX_POSITIONS - 1), ACT_W'(a), VAL_BOTTOM);
    end
    send_item(OP_MARTINGALE, POS_W'(MAX_POSITIONS - 1), ACT_W'(0), VAL_TOP);
    send_item(OP_TERMINAL, POS_W'(MAX_POSITIONS - 1), ACT_W'(3), VAL_TOP);
    send_item(OP_MARTINGALE, POS_W'(0), ACT_W'(0), VAL_BOTTOM);
    send_item(OP_TERMINAL, POS_W'(0), ACT_W'(1), VAL_BOTTOM);
    make_eval(POS_W'(0), ACT_W'(0));
    make_eval(POS_W'(MAX_POSITIONS - 1), ACT_W'(MAX_ACTIONS - 1));
    send_item(OP_SET_NEXT, POS_W'(3), ACT_W'(1), VAL_W'(MAX_POSITIONS));
    send_item(OP_SET_NEXT, POS_W'(2), ACT_W'(2), '1);
    send_item(OP_SPARE_LO, POS_W'(5), ACT_W'(0), '0);
    send_item(OP_SPARE_HI, POS_W'(10), ACT_W'(3), VAL_TOP);
    send_item(OP_ADVANCE, POS_W'(7), ACT_W'(2), '0);
  endtask

  // Mostly evaluates and well-formed loads, with some noise words mixed in,
  // until count more words have gone out, loads for evaluates included.
  task automatic random_words(input int count);
    int i, stop;
    logic [OP_W-1:0] op;
    i    = 0;
    stop = words_sent + count;
    while (words_sent < stop) begin
      if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: make_eval(pick_pos(), pick_act());
        6: send_item(OP_ADVANCE, pick_pos(), pick_act(), draw_wide());
        7, 8: begin
          op = OP_W'($urandom_range(0, 7));
          if (op == OP_EVALUATE)
            make_eval(POS_W'($urandom_range(0, MAX_POSITIONS - 1)),
                      ACT_W'($urandom_range(0, MAX_ACTIONS - 1)));
          else
            send_item(op, POS_W'($urandom_range(0, MAX_POSITIONS - 1)),
                      ACT_W'($urandom_range(0, MAX_ACTIONS - 1)), draw_wide());
        end
        default: begin
          op = OP_W'($urandom_range(OP_SET_NEXT, OP_REWARD));
          send_item(op, pick_pos(), pick_act(),
                    (op == OP_SET_NEXT) ? pick_target() : draw_value());
        end
      endcase
      i++;
    end
  endtask

  // Result side: a random stall before each result word, with stall-free stretches.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Main sequence: reset, directed words, then one random phase per register setting.
  initial begin
    int k;
    rst_n          <= 1'b0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= OP_SET_NEXT;
    in_ch.position <= '0;
    in_ch.action   <= '0;
    in_ch.value    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_access(REG_POSITIONS, 1'b0, '0);
    cfg_access(REG_ACTIONS, 1'b0, '0);
    np_eff = NP_SETTINGS[0];
    na_eff = NA_SETTINGS[0];
    run_directed();
    random_words(PHASE_WORDS);
    drain();
    for (k = 1; k < SETTING_COUNT; k++) begin
      set_counts(NP_SETTINGS[k], NA_SETTINGS[k]);
      random_words(PHASE_WORDS);
      drain();
    end
    repeat (30) @(posedge clk);
    $display("Sent %0d words, %0d of them evaluates, over %0d register settings",
             words_sent, evals_sent, SETTING_COUNT);
    $display("with random gaps and stalls on both channels.");
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("Timeout with %0d result words still expected", pending);
    $display("Mismatches found");
    $finish;
  end

endmodule
